// ===== hw/rtl/pm_timer_lost_tick_accounting_assert.svh =====
// assertion macros used by the lost-tick accounting rtl
`ifndef PM_TIMER_LOST_TICK_ACCOUNTING_ASSERT_SVH
`define PM_TIMER_LOST_TICK_ACCOUNTING_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PMTLA_ASSERT_IMPL(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PMTLA_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pmtla_pkg.sv =====
// constants and types of the lost-tick accounting block
package pmtla_pkg;

    localparam int ACTION_W = 2;
    localparam int SAMPLE_W = 24;
    localparam int WIDE_W   = 64;
    localparam int MISSED_W = 24;
    localparam int OFFSET_W = 33;
    localparam int PERIOD_W = 20;
    localparam int FREQ_W   = 24;
    localparam int US_W     = 22;
    localparam int US_SUM_W = 23;
    localparam int PROD_W   = PERIOD_W + FREQ_W;
    localparam int KREM_W   = 10;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESUME = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CPU_FREQ    = 8'd1;

    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 20'd1000;
    localparam logic [FREQ_W-1:0]   CPU_FREQ_RST    = 24'd1000000;

    localparam logic [31:0] US_NUM    = 32'd286;
    localparam logic [31:0] NS_PER_US = 32'd1000;
    localparam logic [KREM_W:0] KHZ_DIV = 11'd1000;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_ns;
        logic [WIDE_W-1:0]   tsc_base;
        logic [WIDE_W-1:0]   monotonic_ns;
        logic [MISSED_W-1:0] missed_ticks;
    } result_t;

endpackage

// ===== hw/rtl/pm_timer_lost_tick_accounting.sv =====
// lost-tick accounting for a free-running power management timer
//
// input words arrive on s_tvalid/s_tready: s_tuser carries the action, s_tdata
// the counter sample and the timestamp counter sample. every input word gives
// one result word on m_tvalid/m_tready.
// configuration writes on cfg_valid/cfg_ready (always ready) set the tick
// period (index 0) and the timestamp counter frequency (index 1); write only
// while no word is in flight.
// a tick passes through conversion, preparation, a bit-serial restoring
// divide by the tick period, a multiply of the remainder by the frequency,
// a bit-serial divide of that product by 1000 and the finish state. query,
// resume and the unused action go from preparation straight to finish.
// one word is worked on at a time; s_tready is high only while idle. the
// result register lets the next word be taken while a result waits, and a
// stalled receiver holds the finished word until the output slot frees.
// reset (rst_n low, asynchronous) restores the register defaults, clears the
// last sample, the remainder and the monotonic base, and arms the first-tick
// flag.
`include "pm_timer_lost_tick_accounting_assert.svh"

module pm_timer_lost_tick_accounting #(
    parameter int COUNTER_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // counter_sample[23:0], tsc_sample[87:24]
    input  logic [87:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // missed_ticks[23:0], monotonic_ns[87:24], tsc_base[151:88],
    // offset_ns[184:152], zero[191:185]
    output logic [191:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [pmtla_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmtla_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(pmtla_pkg::PROD_W);
    localparam logic [9:0] NS_PER_US_C = pmtla_pkg::NS_PER_US[9:0];

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CONV   = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_KDIV   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [pmtla_pkg::PERIOD_W-1:0] period_cfg_reg;
    logic [pmtla_pkg::FREQ_W-1:0]   freq_cfg_reg;

    logic [COUNTER_BITS-1:0]        last_reg;
    logic [pmtla_pkg::PERIOD_W-1:0] rem_reg;
    logic                           first_reg;
    logic [pmtla_pkg::WIDE_W-1:0]   mono_reg;

    logic [pmtla_pkg::ACTION_W-1:0] act_reg;
    logic [COUNTER_BITS-1:0]        now_reg;
    logic [pmtla_pkg::WIDE_W-1:0]   tsc_reg;
    logic [pmtla_pkg::US_W-1:0]     us_reg;
    logic [pmtla_pkg::OFFSET_W-1:0] offs_reg;
    logic [pmtla_pkg::MISSED_W-1:0] missed_reg;

    // divide by tick period: remainder and numerator/quotient shift register
    logic [pmtla_pkg::PERIOD_W-1:0] dr_reg;
    logic [pmtla_pkg::US_SUM_W-1:0] dn_reg;
    // divide by 1000: remainder and numerator/quotient shift register
    logic [pmtla_pkg::KREM_W-1:0]   kr_reg;
    logic [pmtla_pkg::PROD_W-1:0]   kn_reg;
    logic [CNT_W-1:0]               cnt_reg;

    logic                           m_tvalid_reg;
    pmtla_pkg::result_t             result_reg;

    logic [31:0]                    sample_ext;
    logic [COUNTER_BITS-1:0]        now_in;
    logic [COUNTER_BITS-1:0]        delta;
    logic [31:0]                    us_prod;
    logic [pmtla_pkg::PERIOD_W-1:0] period;
    logic [pmtla_pkg::US_SUM_W-1:0] us_sum;
    logic [31:0]                    mono_inc;
    logic [pmtla_pkg::PERIOD_W:0]   dtrial;
    logic                           dbit;
    logic [pmtla_pkg::KREM_W:0]     ktrial;
    logic                           kbit;
    logic [pmtla_pkg::PROD_W-1:0]   rem_freq;
    logic                           out_free;
    logic                           is_tick;

    assign sample_ext = {8'd0, s_tdata[pmtla_pkg::SAMPLE_W-1:0]};
    assign now_in     = sample_ext[COUNTER_BITS-1:0];
    assign delta      = now_reg - last_reg;
    // product kept to 32 bits before the shift
    assign us_prod    = 32'(delta) * pmtla_pkg::US_NUM;
    assign period     = (period_cfg_reg == '0) ? pmtla_pkg::PERIOD_W'(1) : period_cfg_reg;
    assign us_sum     = pmtla_pkg::US_SUM_W'(us_reg) + pmtla_pkg::US_SUM_W'(rem_reg);
    assign mono_inc   = 32'(us_reg) * pmtla_pkg::NS_PER_US;

    assign dtrial = {dr_reg, dn_reg[pmtla_pkg::US_SUM_W-1]};
    assign dbit   = (dtrial >= {1'b0, period});
    assign ktrial = {kr_reg, kn_reg[pmtla_pkg::PROD_W-1]};
    assign kbit   = (ktrial >= pmtla_pkg::KHZ_DIV);

    assign rem_freq = pmtla_pkg::PROD_W'(dr_reg) * pmtla_pkg::PROD_W'(freq_cfg_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_tick  = (act_reg == pmtla_pkg::ACT_TICK);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, result_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:   state_next = ST_PREP;
            ST_PREP:   state_next = is_tick ? ST_DIV : ST_FINISH;
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_KDIV;
            ST_KDIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            period_cfg_reg <= pmtla_pkg::TICK_PERIOD_RST;
            freq_cfg_reg   <= pmtla_pkg::CPU_FREQ_RST;
            last_reg       <= '0;
            rem_reg        <= '0;
            first_reg      <= 1'b1;
            mono_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pmtla_pkg::REG_TICK_PERIOD:
                        period_cfg_reg <= cfg_data[pmtla_pkg::PERIOD_W-1:0];
                    pmtla_pkg::REG_CPU_FREQ:
                        freq_cfg_reg <= cfg_data[pmtla_pkg::FREQ_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_FINISH && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_PREP:
                begin
                    if (is_tick)
                    begin
                        last_reg <= now_reg;
                        mono_reg <= mono_reg + pmtla_pkg::WIDE_W'(mono_inc);
                        cnt_reg  <= CNT_W'(pmtla_pkg::US_SUM_W - 1);
                    end
                    else if (act_reg == pmtla_pkg::ACT_RESUME)
                    begin
                        last_reg <= now_reg;
                    end
                end
                ST_DIV:    cnt_reg <= cnt_reg - 1'b1;
                ST_MUL:
                begin
                    // remainder stays only when a whole tick passed after the first
                    if (first_reg || dn_reg == '0)
                    begin
                        rem_reg <= '0;
                    end
                    else
                    begin
                        rem_reg <= dr_reg;
                    end
                    first_reg <= 1'b0;
                    cnt_reg   <= CNT_W'(pmtla_pkg::PROD_W - 1);
                end
                ST_KDIV:   cnt_reg <= cnt_reg - 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_reg <= s_tuser;
                    now_reg <= now_in;
                    tsc_reg <= s_tdata[pmtla_pkg::SAMPLE_W +: pmtla_pkg::WIDE_W];
                end
            end
            ST_CONV:   us_reg <= us_prod[31:10];
            ST_PREP:
            begin
                offs_reg <= pmtla_pkg::OFFSET_W'(us_sum) * pmtla_pkg::OFFSET_W'(NS_PER_US_C);
                dn_reg   <= us_sum;
                dr_reg   <= '0;
            end
            ST_DIV:
            begin
                dr_reg <= dbit ? pmtla_pkg::PERIOD_W'(dtrial - {1'b0, period})
                               : dtrial[pmtla_pkg::PERIOD_W-1:0];
                dn_reg <= {dn_reg[pmtla_pkg::US_SUM_W-2:0], dbit};
            end
            ST_MUL:
            begin
                missed_reg <= pmtla_pkg::MISSED_W'(dn_reg) - 1'b1;
                kn_reg     <= rem_freq;
                kr_reg     <= '0;
            end
            ST_KDIV:
            begin
                kr_reg <= kbit ? pmtla_pkg::KREM_W'(ktrial - pmtla_pkg::KHZ_DIV)
                               : ktrial[pmtla_pkg::KREM_W-1:0];
                kn_reg <= {kn_reg[pmtla_pkg::PROD_W-2:0], kbit};
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_reg.missed_ticks <= is_tick ? missed_reg : '0;
                    result_reg.monotonic_ns <= mono_reg;
                    result_reg.tsc_base     <= is_tick
                        ? tsc_reg - pmtla_pkg::WIDE_W'(kn_reg) : '0;
                    result_reg.offset_ns    <= (act_reg == pmtla_pkg::ACT_QUERY)
                        ? offs_reg : '0;
                end
            end
            default: ;
        endcase
    end

    `PMTLA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready,
        state_reg != ST_IDLE, "block still ready after taking a word")
    `PMTLA_ASSERT_IMPL(a_div_rem_range, clk, rst_n, state_reg == ST_MUL,
        dr_reg < period, "tick division remainder not below the period")
    `PMTLA_ASSERT_IMPL(a_kdiv_rem_range, clk, rst_n, state_reg == ST_KDIV,
        {1'b0, kr_reg} < pmtla_pkg::KHZ_DIV, "divide by 1000 remainder out of range")
    `PMTLA_ASSERT_NEXT(a_first_cleared, clk, rst_n, state_reg == ST_MUL,
        !first_reg, "first tick flag not cleared after a tick")
    `PMTLA_ASSERT_NEXT(a_result_shown, clk, rst_n, state_reg == ST_FINISH && out_free,
        m_tvalid_reg && state_reg == ST_IDLE, "finished word not presented")

endmodule

// ===== test/tb_pm_timer_lost_tick_accounting.sv =====
// self-checking testbench for pm_timer_lost_tick_accounting with its own tick accounting model
`timescale 1ns / 1ps

module tb_pm_timer_lost_tick_accounting;

    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam logic [pmtla_pkg::CFG_INDEX_W-1:0] REG_NONE = 8'hFF;
    localparam logic [31:0] US_SCALE     = 32'd286;
    localparam logic [63:0] NS_IN_US     = 64'd1000;
    localparam logic [63:0] KHZ_DIVISOR  = 64'd1000;
    localparam logic [23:0] COUNT_MASK   = 24'hFFFFFF;
    localparam int          RESET_CYCLES = 7;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          TAIL_CYCLES  = 150;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_WORDS  = 115;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // counter_sample[23:0], tsc_sample[87:24]
    logic [87:0]  s_tdata = '0;
    // action[1:0]
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // missed_ticks[23:0], monotonic_ns[87:24], tsc_base[151:88], offset_ns[184:152]
    logic [191:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [pmtla_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pmtla_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    pm_timer_lost_tick_accounting i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // accounting model state and registers
    logic [19:0] period_reg    = pmtla_pkg::TICK_PERIOD_RST;
    logic [23:0] freq_reg      = pmtla_pkg::CPU_FREQ_RST;
    logic [23:0] last_count    = '0;
    logic [31:0] carry_us      = '0;
    logic        first_pending = 1'b1;
    logic [63:0] mono_ns       = '0;

    pmtla_pkg::result_t predicted_results[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req_cnt = 0;
    int mismatches = 0;
    int words_checked = 0;
    int tick_words = 0;
    int query_words = 0;
    int resume_words = 0;
    int other_words = 0;
    int lost_tick_events = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    function automatic pmtla_pkg::result_t account_word(input logic [1:0] act,
                                                        input logic [23:0] now,
                                                        input logic [63:0] tsc);
        pmtla_pkg::result_t r;
        logic [23:0] delta;
        logic [31:0] scaled;
        logic [31:0] us;
        logic [31:0] per;
        logic [31:0] lost;
        r = '0;
        delta = (now - last_count) & COUNT_MASK;
        // product wraps at 32 bits before the shift
        scaled = {8'd0, delta} * US_SCALE;
        us = scaled >> 10;
        case (act)
            pmtla_pkg::ACT_TICK:
            begin
                per = (period_reg == '0) ? 32'd1 : {12'd0, period_reg};
                last_count = now;
                mono_ns = mono_ns + 64'(us) * NS_IN_US;
                us = us + carry_us;
                lost = us / per;
                carry_us = us % per;
                r.tsc_base = tsc - (64'(carry_us) * 64'(freq_reg)) / KHZ_DIVISOR;
                if (first_pending || lost == 0)
                begin
                    first_pending = 1'b0;
                    carry_us = '0;
                end
                r.missed_ticks = 24'(lost - 32'd1);
                if (lost > 1)
                    lost_tick_events++;
                tick_words++;
            end
            pmtla_pkg::ACT_QUERY:
            begin
                r.offset_ns = 33'((64'(carry_us) + 64'(us)) * NS_IN_US);
                query_words++;
            end
            pmtla_pkg::ACT_RESUME:
            begin
                last_count = now;
                resume_words++;
            end
            default:
                other_words++;
        endcase
        r.monotonic_ns = mono_ns;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                 words_checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        pmtla_pkg::result_t got;
        pmtla_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[184:0];
            if (predicted_results.size() == 0)
                report_mismatch("unexpected word", got.monotonic_ns, '0);
            else
            begin
                want = predicted_results.pop_front();
                if (got.missed_ticks != want.missed_ticks)
                    report_mismatch("missed_ticks", 64'(got.missed_ticks),
                                    64'(want.missed_ticks));
                if (got.monotonic_ns != want.monotonic_ns)
                    report_mismatch("monotonic_ns", got.monotonic_ns, want.monotonic_ns);
                if (got.tsc_base != want.tsc_base)
                    report_mismatch("tsc_base", got.tsc_base, want.tsc_base);
                if (got.offset_ns != want.offset_ns)
                    report_mismatch("offset_ns", 64'(got.offset_ns), 64'(want.offset_ns));
                if (m_tdata[191:185] != '0)
                    report_mismatch("pad bits", 64'(m_tdata[191:185]), '0);
            end
            words_checked++;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin : drive_ready
        int hold_left;
        int hold_seen;
        if (hold_seen != hold_req_cnt)
        begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    task automatic send_sample(input logic [1:0] act, input logic [23:0] sample,
                               input logic [63:0] tsc);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {tsc, sample};
        do
            @(posedge clk);
        while (!s_tready);
        predicted_results.push_back(account_word(act, sample, tsc));
    endtask

    task automatic release_and_drain();
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [pmtla_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pmtla_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == pmtla_pkg::REG_TICK_PERIOD)
            period_reg = data[19:0];
        else if (idx == pmtla_pkg::REG_CPU_FREQ)
            freq_reg = data[23:0];
        reg_writes++;
    endtask

    task automatic configure_random();
        logic [19:0] per;
        logic [23:0] freq;
        case ($urandom_range(0, 5))
            0:       per = '0;
            1:       per = 20'($urandom_range(1, 20));
            2:       per = 20'd1000;
            3:       per = 20'hFFFFF;
            default: per = 20'($urandom_range(1, 100000));
        endcase
        case ($urandom_range(0, 4))
            0:       freq = '0;
            1:       freq = 24'd1;
            2:       freq = 24'hFFFFFF;
            default: freq = 24'($urandom);
        endcase
        // upper data bits are don't-care for both registers
        write_reg(pmtla_pkg::REG_TICK_PERIOD, ($urandom & 32'hFFF0_0000) | 32'(per));
        write_reg(pmtla_pkg::REG_CPU_FREQ, ($urandom & 32'hFF00_0000) | 32'(freq));
        if ($urandom_range(0, 2) == 0)
            write_reg(8'($urandom_range(2, 255)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // mostly counter steps of up to three whole ticks plus a random part of a tick
    function automatic logic [23:0] next_count();
        logic [63:0] per;
        logic [63:0] us_target;
        logic [63:0] counts;
        int roll;
        per = (period_reg == '0) ? 64'd1 : 64'(period_reg);
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            us_target = 64'($urandom_range(0, 3)) * per
                        + 64'($urandom_range(0, 32'(per) - 1));
            counts = (us_target * 64'd1024) / 64'(US_SCALE) + 64'd1;
            if (counts > 64'(COUNT_MASK))
                counts = 64'($urandom_range(0, 32'(COUNT_MASK)));
            return last_count + counts[23:0];
        end
        else if (roll < 85)
            return last_count + 24'($urandom_range(0, 4000));
        else
            return 24'($urandom);
    endfunction

    task automatic send_random_word();
        logic [1:0] act;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            act = pmtla_pkg::ACT_TICK;
        else if (roll < 78)
            act = pmtla_pkg::ACT_QUERY;
        else if (roll < 92)
            act = pmtla_pkg::ACT_RESUME;
        else
            act = ACT_UNUSED;
        send_sample(act, next_count(), {$urandom, $urandom});
    endtask

    task automatic test_directed_defaults();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_sample(pmtla_pkg::ACT_QUERY, 24'h000123, {$urandom, $urandom});
        // first tick with no counter movement
        send_sample(pmtla_pkg::ACT_TICK, 24'h000000, 64'd0);
        send_sample(pmtla_pkg::ACT_TICK, 24'd3581, '1);
        // several whole ticks with a remainder carried, timestamp base wraps
        send_sample(pmtla_pkg::ACT_TICK, last_count + 24'd12000, 64'd0);
        send_sample(pmtla_pkg::ACT_QUERY, last_count + 24'd100, {$urandom, $urandom});
        // full-range delta, product truncated
        send_sample(pmtla_pkg::ACT_TICK, last_count - 24'd1, '1);
        send_sample(pmtla_pkg::ACT_RESUME, 24'hFFFF00, {$urandom, $urandom});
        send_sample(pmtla_pkg::ACT_TICK, 24'h000100, {$urandom, $urandom});
        send_sample(pmtla_pkg::ACT_QUERY, 24'h000000, {$urandom, $urandom});
        send_sample(ACT_UNUSED, 24'hFFFFFF, '1);
        send_sample(pmtla_pkg::ACT_TICK, last_count + 24'd500, {$urandom, $urandom});
        release_and_drain();
    endtask

    task automatic test_register_extremes();
        // zero period behaves as one microsecond
        write_reg(pmtla_pkg::REG_TICK_PERIOD, 32'hFFF0_0000);
        write_reg(pmtla_pkg::REG_CPU_FREQ, 32'hFFFF_FFFF);
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_sample(pmtla_pkg::ACT_TICK, last_count + 24'd5000, {$urandom, $urandom});
        send_sample(pmtla_pkg::ACT_QUERY, last_count + 24'd7, {$urandom, $urandom});
        send_sample(pmtla_pkg::ACT_TICK, last_count, {$urandom, $urandom});
        release_and_drain();
        // widest period with a large remainder and widest offset
        write_reg(pmtla_pkg::REG_TICK_PERIOD, 32'h000F_FFFF);
        write_reg(pmtla_pkg::REG_CPU_FREQ, 32'h00FF_FFFF);
        cfg_valid <= 1'b0;
        send_sample(pmtla_pkg::ACT_TICK, last_count + 24'd15017000, {$urandom, $urandom});
        send_sample(pmtla_pkg::ACT_QUERY, last_count + 24'd15017000, {$urandom, $urandom});
        release_and_drain();
        write_reg(pmtla_pkg::REG_CPU_FREQ, 32'h0000_0000);
        cfg_valid <= 1'b0;
        send_sample(pmtla_pkg::ACT_TICK, last_count + 24'd15017000, {$urandom, $urandom});
        release_and_drain();
        write_reg(pmtla_pkg::REG_CPU_FREQ, 32'h0000_0001);
        cfg_valid <= 1'b0;
        send_sample(pmtla_pkg::ACT_TICK, last_count + 24'd3, {$urandom, $urandom});
        release_and_drain();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        configure_random();
        tx_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (PHASE_WORDS)
            send_random_word();
        release_and_drain();
    endtask

    task automatic test_output_hold_off();
        configure_random();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req_cnt++;
        repeat (12)
            send_random_word();
        release_and_drain();
    endtask

    task automatic test_drain_pause();
        tx_idle_pct = 0;
        rx_stall_pct = 31;
        repeat (6)
            send_random_word();
        release_and_drain();
        repeat (6)
            send_random_word();
        release_and_drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_register_extremes();
        test_random_phase(0, 0);
        test_random_phase(61, 0);
        test_random_phase(0, 61);
        test_random_phase(31, 31);
        test_output_hold_off();
        test_drain_pause();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("covered %0d ticks (%0d with lost ticks), %0d queries, %0d resumes, %0d unused",
                 tick_words, lost_tick_events, query_words, resume_words, other_words);
        $display("%0d results checked, %0d register writes, %0d mismatches",
                 words_checked, reg_writes, mismatches);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pmtla_pkg.sv
hw/rtl/pm_timer_lost_tick_accounting.sv
test/tb_pm_timer_lost_tick_accounting.sv
